>>> design/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants and functions for the circle center projector.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int HORNER_STAGES    = 3;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    localparam logic [2:0] REG_TERM_COUNT = 3'd0;
    localparam logic [2:0] REG_COEFF_A    = 3'd1;
    localparam logic [2:0] REG_COEFF_B    = 3'd2;
    localparam logic [2:0] REG_COEFF_C    = 3'd3;
    localparam logic [2:0] REG_COEFF_D    = 3'd4;
    localparam logic [2:0] REG_RADIUS     = 3'd5;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic [15:0]        angle;
        logic signed [31:0] mean_range;
        logic [15:0]        mean_bearing;
        logic [31:0]        stamp;
        logic [2:0]         terms;
        logic signed [31:0] coeff_a;
        logic signed [31:0] coeff_b;
        logic signed [31:0] coeff_c;
        logic signed [31:0] coeff_d;
        logic [30:0]        radius;
        logic               valid;
    } t_job;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_range;
        logic [15:0]        center_bearing;
        logic [31:0]        center_stamp;
        logic [30:0]        radius_out;
        logic               result_valid;
    } t_result;

    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

>>> design/circle_center_from_scan_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_center_from_scan_top
// Range correction and polar projection of one scan object per transfer.
// Path from push to result: job queue, Horner stages, CORDIC stages, projection
//   multiply and add, then the result queue.
// Throughput: one item per cycle while results are popped.
// Reset: synchronous active low; clears queues and loads default registers.
// ----------------------------------------------------------------------------
module circle_center_from_scan_top #(
    parameter int CORDIC_STEPS = ccs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_view_x,
    input  logic signed [31:0] i_view_y,
    input  logic [15:0]        i_view_heading,
    input  logic signed [31:0] i_mean_range,
    input  logic [15:0]        i_mean_bearing,
    input  logic [31:0]        i_stamp,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [31:0] o_center_range,
    output logic [15:0]        o_center_bearing,
    output logic [31:0]        o_center_stamp,
    output logic [30:0]        o_radius_out,
    output logic               o_result_valid
);
    import ccs_pkg::*;

    t_job    w_job;
    t_result w_res;
    logic    w_job_valid, w_job_take;

    // front: register file and job queue, stalls only on a full queue
    ccs_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_push(push), .i_view_x, .i_view_y, .i_view_heading,
        .i_mean_range, .i_mean_bearing, .i_stamp,
        .o_full(full), .o_job_valid(w_job_valid), .o_job(w_job),
        .i_job_take(w_job_take)
    );

    // back: arithmetic pipeline draining into the result queue
    ccs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .i_job(w_job),
        .o_job_take(w_job_take), .o_empty(empty), .i_pop(pop), .o_res(w_res)
    );

    assign o_center_x       = w_res.center_x;
    assign o_center_y       = w_res.center_y;
    assign o_center_range   = w_res.center_range;
    assign o_center_bearing = w_res.center_bearing;
    assign o_center_stamp   = w_res.center_stamp;
    assign o_radius_out     = w_res.radius_out;
    assign o_result_valid   = w_res.result_valid;

endmodule

>>> design/ccs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front
// Configuration registers; classify each item and queue it as a job.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_push,
    input  logic signed [31:0]  i_view_x,
    input  logic signed [31:0]  i_view_y,
    input  logic [15:0]         i_view_heading,
    input  logic signed [31:0]  i_mean_range,
    input  logic [15:0]         i_mean_bearing,
    input  logic [31:0]         i_stamp,
    output logic                o_full,
    output logic                o_job_valid,
    output ccs_pkg::t_job       o_job,
    input  logic                i_job_take
);
    import ccs_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [2:0]         r_terms;
    logic signed [31:0] r_coeff [4];
    logic [30:0]        r_radius;

    t_job               r_mem [FIFO_DEPTH];
    logic [AW:0]        r_wp, r_rp;
    t_job               w_job;
    logic               w_push_ok, w_take_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terms    <= 3'd2;
            r_coeff[0] <= 32'sd65536;
            r_coeff[1] <= 32'sd2228;
            r_coeff[2] <= 32'sd0;
            r_coeff[3] <= 32'sd0;
            r_radius   <= 31'd2621;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TERM_COUNT: r_terms    <= i_cfg_data[2:0];
                REG_COEFF_A:    r_coeff[0] <= i_cfg_data;
                REG_COEFF_B:    r_coeff[1] <= i_cfg_data;
                REG_COEFF_C:    r_coeff[2] <= i_cfg_data;
                REG_COEFF_D:    r_coeff[3] <= i_cfg_data;
                REG_RADIUS:     r_radius   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_job              = '0;
        w_job.view_x       = i_view_x;
        w_job.view_y       = i_view_y;
        w_job.angle        = i_view_heading + i_mean_bearing;
        w_job.mean_range   = i_mean_range;
        w_job.mean_bearing = i_mean_bearing;
        w_job.stamp        = i_stamp;
        w_job.terms        = (r_terms > 3'd4) ? 3'd4 : r_terms;
        w_job.coeff_a      = r_coeff[0];
        w_job.coeff_b      = r_coeff[1];
        w_job.coeff_c      = r_coeff[2];
        w_job.coeff_d      = r_coeff[3];
        w_job.radius       = r_radius;
        w_job.valid        = (r_radius != 31'd0) && (r_terms != 3'd0);
    end

    assign o_full      = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_job_valid = (r_wp != r_rp);
    assign o_job       = r_mem[r_rp[AW-1:0]];
    assign w_push_ok   = i_push && !o_full;
    assign w_take_ok   = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_mem[r_wp[AW-1:0]] <= w_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_push_ok) r_wp <= r_wp + 1'b1;
            if (w_take_ok) r_rp <= r_rp + 1'b1;
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) <= (AW+1)'(FIFO_DEPTH)) else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> o_job_valid) else $error("full while empty");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && !i_job_take) |=> o_job_valid) else $error("job lost");

endmodule

>>> design/ccs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_back
// Horner stages, CORDIC stages and projection; pipeline with stall and
// a result queue at the end.
// ----------------------------------------------------------------------------
module ccs_back #(
    parameter int CORDIC_STEPS = ccs_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  ccs_pkg::t_job     i_job,
    output logic              o_job_take,
    output logic              o_empty,
    input  logic              i_pop,
    output ccs_pkg::t_result  o_res
);
    import ccs_pkg::*;

    // stages: 2 per Horner step (multiply, add), a pass stage, CORDIC steps, 1 multiply, 1 register; add after it
    localparam int HS  = 2 * HORNER_STAGES;
    localparam int NST = HS + 1 + CORDIC_STEPS + 2;
    localparam int OQ  = 4;
    localparam int OQD = NST + OQ;
    localparam int QAW = $clog2(OQD);

    typedef struct packed {
        t_job               job;
        logic signed [31:0] acc;
        logic signed [63:0] prod;
        logic [31:0]        z;
        logic               flip;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [63:0] px;
        logic signed [63:0] py;
    } t_pipe;

    t_pipe          r_p [NST+1];
    logic           r_v [NST+1];
    t_pipe          n_p [NST+1];
    logic           w_adv;

    t_result        r_q [OQD];
    logic [QAW:0]   r_wp, r_rp, r_cnt;
    logic [QAW:0]   w_inflight;
    t_result        w_res;

    // advance while the result queue can absorb everything in flight
    always_comb begin
        w_inflight = '0;
        for (int k = 0; k <= NST; k++) w_inflight = w_inflight + (QAW+1)'(r_v[k]);
    end
    assign w_adv      = (32'(r_cnt) + 32'(w_inflight)) < OQD;
    assign o_job_take = w_adv;

    always_comb begin
        logic signed [31:0] cf;
        logic signed [63:0] dx, dy;
        logic [15:0] t16;
        n_p[0] = '0;
        n_p[0].job  = i_job;
        n_p[0].acc  = i_job.coeff_a;
        t16 = i_job.angle + 16'h4000;
        n_p[0].flip = t16[15];
        n_p[0].z    = {i_job.angle, 16'h0} - (t16[15] ? 32'h80000000 : 32'h0);
        n_p[0].cx   = 34'(signed'(CORDIC_GAIN_Q30));
        n_p[0].cy   = '0;
        for (int k = 1; k <= NST; k++) begin
            n_p[k] = r_p[k-1];
            if (k <= HS) begin
                if ((k % 2) == 1) begin
                    n_p[k].prod = 64'(r_p[k-1].acc) * 64'(r_p[k-1].job.mean_range);
                end else begin
                    case (k / 2)
                        1:       cf = r_p[k-1].job.coeff_b;
                        2:       cf = r_p[k-1].job.coeff_c;
                        default: cf = r_p[k-1].job.coeff_d;
                    endcase
                    if (32'(r_p[k-1].job.terms) > (k / 2))
                        n_p[k].acc = sat32(66'(sat32(66'(r_p[k-1].prod >>> 16))) + 66'(cf));
                end
            end else if (k == HS + 1) begin
                n_p[k] = r_p[k-1];
            end else if (k <= HS + 1 + CORDIC_STEPS) begin
                dx = 64'(r_p[k-1].cy) >>> (k - HS - 2);
                dy = 64'(r_p[k-1].cx) >>> (k - HS - 2);
                if (!r_p[k-1].z[31]) begin
                    n_p[k].cx = 34'(64'(r_p[k-1].cx) - dx);
                    n_p[k].cy = 34'(64'(r_p[k-1].cy) + dy);
                    n_p[k].z  = r_p[k-1].z - atan_turns(5'(k - HS - 2));
                end else begin
                    n_p[k].cx = 34'(64'(r_p[k-1].cx) + dx);
                    n_p[k].cy = 34'(64'(r_p[k-1].cy) - dy);
                    n_p[k].z  = r_p[k-1].z + atan_turns(5'(k - HS - 2));
                end
                if (k == HS + 1 + CORDIC_STEPS && r_p[k-1].flip) begin
                    n_p[k].cx = -n_p[k].cx;
                    n_p[k].cy = -n_p[k].cy;
                end
            end else if (k == NST - 1) begin
                n_p[k].px = 64'(r_p[k-1].acc) * 64'(r_p[k-1].cx);
                n_p[k].py = 64'(r_p[k-1].acc) * 64'(r_p[k-1].cy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= n_p[0];
            for (int k = 1; k <= NST; k++) r_p[k] <= n_p[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_job_valid;
            for (int k = 1; k <= NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    // final add and the invalid-job case (zero radius or zero term count)
    always_comb begin
        t_pipe e;
        e = r_p[NST];
        w_res = '0;
        if (e.job.valid) begin
            w_res.center_x       = sat32(66'(e.job.view_x) + 66'(e.px >>> 30));
            w_res.center_y       = sat32(66'(e.job.view_y) + 66'(e.py >>> 30));
            w_res.center_range   = e.acc;
            w_res.center_bearing = e.job.mean_bearing;
            w_res.center_stamp   = e.job.stamp;
            w_res.radius_out     = e.job.radius;
            w_res.result_valid   = 1'b1;
        end
    end

    logic w_wr, w_rd;
    assign w_wr    = w_adv && r_v[NST];
    assign w_rd    = i_pop && !o_empty;
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp[QAW-1:0]] <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (32'(r_wp) == OQD - 1) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (32'(r_rp) == OQD - 1) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_wr) - (QAW+1)'(w_rd);
        end
    end

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= OQD) else $error("result queue overflow");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> (r_cnt != '0)) else $error("stall with empty queue");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp)) else $error("queue pointers disagree");

endmodule
